[design/srpc_pkg.sv]
// Shared constants and types for the saturated-run packet checker.
// No dependencies; imported by every module of the block.
`default_nettype none

package srpc_pkg;

  localparam int RUN_LENGTH  = 8;
  localparam int SAMPLE_BITS = 10;
  localparam int RUN_W       = $clog2(RUN_LENGTH);

  localparam int PER_W = 8;
  localparam int ALL_W = 10;
  localparam logic [PER_W-1:0] PER_MAX = {PER_W{1'b1}};
  localparam logic [ALL_W-1:0] ALL_MAX = {ALL_W{1'b1}};

  localparam int LIM_W   = 8;
  localparam int CIDX_W  = 2;
  localparam int PKT_W   = 16;
  localparam int EVT_W   = 32;
  localparam int DIFF_W  = SAMPLE_BITS + 1;

  localparam logic [LIM_W-1:0] TOTAL_LIMIT_RST  = 8'd20;
  localparam logic [LIM_W-1:0] SEVERE_LIMIT_RST = 8'd8;
  localparam logic [LIM_W-1:0] WARN_LIMIT_RST   = 8'd3;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_TOTAL_LIMIT  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_SEVERE_LIMIT = 2'd1;
  localparam logic [CIDX_W-1:0] REG_WARN_LIMIT   = 2'd2;

  typedef enum logic [1:0] {
    CLS_CLEAN    = 2'd0,
    CLS_MINOR    = 2'd1,
    CLS_MODERATE = 2'd2,
    CLS_SEVERE   = 2'd3
  } err_class_t;

  typedef struct packed {
    logic [LIM_W-1:0] total_limit;
    logic [LIM_W-1:0] severe_limit;
    logic [LIM_W-1:0] warn_limit;
  } cfg_t;

  // per-reading status toward the top level
  typedef struct packed {
    logic             hit;       // a cluster completes with this transaction
    logic [PER_W-1:0] clusters;  // count including this transaction
    logic [PER_W-1:0] count;     // registered count before this transaction
  } rdg_stat_t;

endpackage

`default_nettype wire

[design/saturated_run_packet_checker_top.sv]
// Top level of the saturated-run packet checker: input register, reading
// trackers, total count, classification and result register.
// Depends on srpc_pkg, srpc_cfg and srpc_reading.
//
//   channel | direction | handshake         | payload
//   in_     | input     | in_valid/in_stall | three readings, packet, event, last
//   out_    | output    | out_valid/out_stall | difference, classification, echoes
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One transaction per cycle sustained while out_stall is low. Items pass the input
// register, then the result register; counters update as an item enters the latter.
// Synchronous active-low reset clears counters and both valid flags and loads the default limits.
// A stalled result holds; one more transaction is still taken into the input
// register behind it, and in_stall rises only when both registers are full.
`default_nettype none

module saturated_run_packet_checker_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [srpc_pkg::SAMPLE_BITS-1:0] in_time_value,
  input  logic [srpc_pkg::SAMPLE_BITS-1:0] in_post_sample,
  input  logic [srpc_pkg::SAMPLE_BITS-1:0] in_pre_sample,
  input  logic [srpc_pkg::PKT_W-1:0]       in_packet_number,
  input  logic [srpc_pkg::EVT_W-1:0]       in_event_number,
  input  logic                             in_last_channel,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [srpc_pkg::DIFF_W-1:0] out_amplitude_difference,
  output logic                             out_packet_done,
  output logic [1:0]                       out_error_class,
  output logic [srpc_pkg::ALL_W-1:0]       out_cluster_total,
  output logic [srpc_pkg::PKT_W-1:0]       out_packet_echo,
  output logic [srpc_pkg::EVT_W-1:0]       out_event_echo,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [srpc_pkg::CIDX_W-1:0]      cfg_index,
  input  logic [srpc_pkg::LIM_W-1:0]       cfg_data
);
  import srpc_pkg::*;

  cfg_t cfg;

  // input register
  logic                   s1_valid_r;
  logic [SAMPLE_BITS-1:0] s1_time_r, s1_post_r, s1_pre_r;
  logic [PKT_W-1:0]       s1_pkt_r;
  logic [EVT_W-1:0]       s1_evt_r;
  logic                   s1_last_r;

  // result register
  logic                     out_valid_r;
  logic [DIFF_W-1:0]        diff_r;
  logic                     done_r;
  err_class_t               class_r;
  logic [ALL_W-1:0]         total_r;
  logic [PKT_W-1:0]         pkt_echo_r;
  logic [EVT_W-1:0]         evt_echo_r;

  logic [ALL_W-1:0]  all_clusters_r, all_clusters_nxt;
  logic [ALL_W:0]    all_sum;
  logic [1:0]        hit_cnt;
  logic              in_acc;
  logic              adv;
  rdg_stat_t         pre_st, post_st, time_st;
  err_class_t        cls;
  logic [DIFF_W-1:0] diff;

  assign adv      = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  srpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  srpc_reading u_pre (
    .clk (clk), .rst_n (rst_n), .upd (adv), .clr (s1_last_r),
    .sample (s1_pre_r), .stat (pre_st)
  );

  srpc_reading u_post (
    .clk (clk), .rst_n (rst_n), .upd (adv), .clr (s1_last_r),
    .sample (s1_post_r), .stat (post_st)
  );

  srpc_reading u_time (
    .clk (clk), .rst_n (rst_n), .upd (adv), .clr (s1_last_r),
    .sample (s1_time_r), .stat (time_st)
  );

  // total clusters, up to three new ones per transaction, saturating
  always_comb begin
    hit_cnt = {1'b0, pre_st.hit} + {1'b0, post_st.hit} + {1'b0, time_st.hit};
    all_sum = {1'b0, all_clusters_r} + (ALL_W + 1)'(hit_cnt);
    all_clusters_nxt = (all_sum > {1'b0, ALL_MAX}) ? ALL_MAX : all_sum[ALL_W-1:0];
  end

  always_comb begin
    if (all_clusters_nxt > {{(ALL_W - LIM_W){1'b0}}, cfg.total_limit} ||
        pre_st.clusters > cfg.severe_limit ||
        post_st.clusters > cfg.severe_limit ||
        time_st.clusters > cfg.severe_limit) begin
      cls = CLS_SEVERE;
    end else if (pre_st.clusters > cfg.warn_limit ||
                 post_st.clusters > cfg.warn_limit ||
                 time_st.clusters > cfg.warn_limit) begin
      cls = CLS_MODERATE;
    end else if (all_clusters_nxt != '0) begin
      cls = CLS_MINOR;
    end else begin
      cls = CLS_CLEAN;
    end
  end

  assign diff = {1'b0, s1_post_r} - {1'b0, s1_pre_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      all_clusters_r <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (adv) begin
        all_clusters_r <= s1_last_r ? '0 : all_clusters_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_time_r <= in_time_value;
      s1_post_r <= in_post_sample;
      s1_pre_r  <= in_pre_sample;
      s1_pkt_r  <= in_packet_number;
      s1_evt_r  <= in_event_number;
      s1_last_r <= in_last_channel;
    end
    if (adv) begin
      diff_r     <= diff;
      done_r     <= s1_last_r;
      class_r    <= s1_last_r ? cls : CLS_CLEAN;
      total_r    <= s1_last_r ? all_clusters_nxt : '0;
      pkt_echo_r <= s1_last_r ? s1_pkt_r : '0;
      evt_echo_r <= s1_last_r ? s1_evt_r : '0;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_amplitude_difference = diff_r;
  assign out_packet_done          = done_r;
  assign out_error_class          = class_r;
  assign out_cluster_total        = total_r;
  assign out_packet_echo          = pkt_echo_r;
  assign out_event_echo           = evt_echo_r;

  // the total never falls behind the pre-sample or time count
  a_total_covers_pre: assert property (@(posedge clk) disable iff (!rst_n)
    {{(ALL_W - PER_W){1'b0}}, pre_st.count} <= all_clusters_r)
    else $error("total cluster count below pre-sample count");

  a_total_covers_time: assert property (@(posedge clk) disable iff (!rst_n)
    {{(ALL_W - PER_W){1'b0}}, time_st.count} <= all_clusters_r)
    else $error("total cluster count below time count");

  // the end of a packet leaves the total cleared
  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_last_r |=> all_clusters_r == '0)
    else $error("total not cleared after last transaction");

  // items inside a packet carry no classification
  a_mid_packet_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !done_r |-> class_r == CLS_CLEAN && total_r == '0)
    else $error("classification fields set on a non-final transaction");

  // minor means at least one cluster was seen
  a_minor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && done_r && class_r == CLS_MINOR |-> total_r != '0)
    else $error("minor class with an empty cluster total");

endmodule

`default_nettype wire

[design/srpc_cfg.sv]
// Limit registers of the checker, written over the configuration channel.
// Depends on srpc_pkg.
`default_nettype none

module srpc_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [srpc_pkg::CIDX_W-1:0] cfg_index,
  input  logic [srpc_pkg::LIM_W-1:0]  cfg_data,
  output srpc_pkg::cfg_t             cfg
);
  import srpc_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.total_limit  <= TOTAL_LIMIT_RST;
      cfg_r.severe_limit <= SEVERE_LIMIT_RST;
      cfg_r.warn_limit   <= WARN_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TOTAL_LIMIT:  cfg_r.total_limit  <= cfg_data;
        REG_SEVERE_LIMIT: cfg_r.severe_limit <= cfg_data;
        REG_WARN_LIMIT:   cfg_r.warn_limit   <= cfg_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

endmodule

`default_nettype wire

[design/srpc_reading.sv]
// Run counter and saturating cluster counter for one reading.
// Depends on srpc_pkg.
`default_nettype none

module srpc_reading (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            upd,
  input  logic                            clr,
  input  logic [srpc_pkg::SAMPLE_BITS-1:0] sample,
  output srpc_pkg::rdg_stat_t             stat
);
  import srpc_pkg::*;

  logic [RUN_W-1:0] run_r, run_nxt;
  logic [PER_W-1:0] clusters_r, clusters_nxt;
  logic             sat;
  logic             hit;

  assign sat = &sample;
  assign hit = sat && (run_r == RUN_W'(RUN_LENGTH - 1));

  always_comb begin
    run_nxt      = (sat && !hit) ? run_r + 1'b1 : '0;
    clusters_nxt = (hit && clusters_r != PER_MAX) ? clusters_r + 1'b1 : clusters_r;
  end

  assign stat.hit      = hit;
  assign stat.clusters = clusters_nxt;
  assign stat.count    = clusters_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r      <= '0;
      clusters_r <= '0;
    end else if (upd) begin
      run_r      <= clr ? '0 : run_nxt;
      clusters_r <= clr ? '0 : clusters_nxt;
    end
  end

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for saturated_run_packet_checker_top: random and directed
// channel transactions, in-bench cluster predictor, per-field result compare.
// Depends on srpc_pkg and the block's RTL.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import srpc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 200;
  localparam int LONG_ITEMS  = 720;

  // index with no register behind it; the write must be ignored
  localparam logic [CIDX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef struct {
    logic [SAMPLE_BITS-1:0] time_value;
    logic [SAMPLE_BITS-1:0] post_sample;
    logic [SAMPLE_BITS-1:0] pre_sample;
    logic [PKT_W-1:0]       packet_number;
    logic [EVT_W-1:0]       event_number;
    logic                   last_channel;
  } channel_t;

  typedef struct {
    logic [DIFF_W-1:0] diff;
    logic              done;
    err_class_t        cls;
    logic [ALL_W-1:0]  total;
    logic [PKT_W-1:0]  pkt;
    logic [EVT_W-1:0]  evt;
  } channel_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic signed [DIFF_W-1:0] out_amplitude_difference;
  logic                out_packet_done;
  logic [1:0]          out_error_class;
  logic [ALL_W-1:0]    out_cluster_total;
  logic [PKT_W-1:0]    out_packet_echo;
  logic [EVT_W-1:0]    out_event_echo;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CIDX_W-1:0]   cfg_index = '0;
  logic [LIM_W-1:0]    cfg_data = '0;

  channel_t        offer = '{default: '0};
  channel_t        pending[$];
  channel_result_t expected[$];

  // predictor state: index 0 pre, 1 post, 2 time
  int unsigned      run_len[3] = '{0, 0, 0};
  logic [PER_W-1:0] clus[3] = '{0, 0, 0};
  logic [ALL_W-1:0] clus_total = '0;
  cfg_t             limits = {TOTAL_LIMIT_RST, SEVERE_LIMIT_RST, WARN_LIMIT_RST};

  int  errors = 0;
  int  cycles = 0;
  int  items_in = 0;
  int  results_out = 0;
  int  reg_writes = 0;
  int  class_seen[4] = '{0, 0, 0, 0};
  bit  taken = 1'b0;
  bit  no_idle = 1'b0;
  bit  hold_used = 1'b0;
  int  hold_left = 0;

  saturated_run_packet_checker_top u_top (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_time_value           (offer.time_value),
    .in_post_sample          (offer.post_sample),
    .in_pre_sample           (offer.pre_sample),
    .in_packet_number        (offer.packet_number),
    .in_event_number         (offer.event_number),
    .in_last_channel         (offer.last_channel),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_amplitude_difference(out_amplitude_difference),
    .out_packet_done         (out_packet_done),
    .out_error_class         (out_error_class),
    .out_cluster_total       (out_cluster_total),
    .out_packet_echo         (out_packet_echo),
    .out_event_echo          (out_event_echo),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void track_reading(int r, logic [SAMPLE_BITS-1:0] v);
    if (v == {SAMPLE_BITS{1'b1}}) begin
      run_len[r]++;
      if (run_len[r] >= RUN_LENGTH) begin
        run_len[r] = 0;
        if (clus[r] != PER_MAX) clus[r]++;
        if (clus_total != ALL_MAX) clus_total++;
      end
    end else begin
      run_len[r] = 0;
    end
  endfunction

  function automatic channel_result_t predict_channel(channel_t ch);
    channel_result_t r;
    bit sev;
    bit mod;
    int i;
    r.diff  = {1'b0, ch.post_sample} - {1'b0, ch.pre_sample};
    r.done  = 1'b0;
    r.cls   = CLS_CLEAN;
    r.total = '0;
    r.pkt   = '0;
    r.evt   = '0;
    track_reading(0, ch.pre_sample);
    track_reading(1, ch.post_sample);
    track_reading(2, ch.time_value);
    if (ch.last_channel) begin
      sev = clus_total > limits.total_limit;
      mod = 1'b0;
      for (i = 0; i < 3; i++) begin
        sev |= clus[i] > limits.severe_limit;
        mod |= clus[i] > limits.warn_limit;
      end
      r.done  = 1'b1;
      r.cls   = sev ? CLS_SEVERE : mod ? CLS_MODERATE :
                (clus_total != 0) ? CLS_MINOR : CLS_CLEAN;
      r.total = clus_total;
      r.pkt   = ch.packet_number;
      r.evt   = ch.event_number;
      class_seen[r.cls]++;
      for (i = 0; i < 3; i++) begin
        run_len[i] = 0;
        clus[i] = '0;
      end
      clus_total = '0;
    end
    return r;
  endfunction

  function automatic channel_t mk_channel(logic [SAMPLE_BITS-1:0] t, logic [SAMPLE_BITS-1:0] post,
                                          logic [SAMPLE_BITS-1:0] pre, logic [PKT_W-1:0] pkt,
                                          logic [EVT_W-1:0] evt, logic last);
    channel_t ch;
    ch.time_value    = t;
    ch.post_sample   = post;
    ch.pre_sample    = pre;
    ch.packet_number = pkt;
    ch.event_number  = evt;
    ch.last_channel  = last;
    return ch;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_reading(int ones_pct);
    logic [SAMPLE_BITS-1:0] v;
    v = SAMPLE_BITS'($urandom);
    if ($urandom_range(99) < ones_pct) v = '1;
    return v;
  endfunction

  task automatic queue_packet(int len, int ones_pct);
    logic [PKT_W-1:0] pkt;
    int i;
    pkt = PKT_W'($urandom);
    for (i = 0; i < len; i++) begin
      pending.push_back(mk_channel(pick_reading(ones_pct), pick_reading(ones_pct),
                                   pick_reading(ones_pct), pkt, $urandom, i == len - 1));
    end
  endtask

  // mostly well-formed packets with long saturated runs, some noise and
  // short broken packets
  task automatic queue_random(int n);
    int count;
    int len;
    int pct;
    int kind;
    count = 0;
    while (count < n) begin
      kind = $urandom_range(9);
      if (kind < 7) begin
        len = $urandom_range(64, 1);
        case ($urandom_range(2))
          0: pct = 100;
          1: pct = 95;
          default: pct = 80;
        endcase
      end else if (kind < 9) begin
        len = $urandom_range(16, 1);
        pct = $urandom_range(50);
      end else begin
        len = $urandom_range(4, 1);
        pct = 100;
      end
      queue_packet(len, pct);
      count += len;
    end
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [LIM_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TOTAL_LIMIT:  limits.total_limit  = val;
      REG_SEVERE_LIMIT: limits.severe_limit = val;
      REG_WARN_LIMIT:   limits.warn_limit   = val;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_limits(logic [LIM_W-1:0] tot, logic [LIM_W-1:0] sev,
                            logic [LIM_W-1:0] warn);
    write_reg(REG_TOTAL_LIMIT, tot);
    write_reg(REG_SEVERE_LIMIT, sev);
    write_reg(REG_WARN_LIMIT, warn);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending.size() != 0 || in_valid || expected.size() != 0);
  endtask

  task automatic mismatch(string field, logic [63:0] exp_v, logic [63:0] act_v);
    errors++;
    $error("%s: expected 0x%0h, got 0x%0h", field, exp_v, act_v);
  endtask

  // input side: record the transaction at the edge, present the next at the fall
  always @(posedge clk) begin
    taken = 1'b0;
    if (rst_n && in_valid && !in_stall) begin
      expected.push_back(predict_channel(offer));
      items_in++;
      taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || taken)) begin
      if (pending.size() != 0 && (no_idle || $urandom_range(99) >= 16)) begin
        offer = pending.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side stall, with one long hold-off to back the block up
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_used && items_in >= 120) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(99) < 16);
    end
  end

  always @(posedge clk) begin
    channel_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      results_out++;
      if (expected.size() == 0) begin
        errors++;
        $error("result transaction with nothing expected");
      end else begin
        e = expected.pop_front();
        if (out_amplitude_difference !== e.diff)
          mismatch("amplitude_difference", e.diff, out_amplitude_difference);
        if (out_packet_done !== e.done) mismatch("packet_done", e.done, out_packet_done);
        if (out_error_class !== e.cls) mismatch("error_class", e.cls, out_error_class);
        if (out_cluster_total !== e.total)
          mismatch("cluster_total", e.total, out_cluster_total);
        if (out_packet_echo !== e.pkt) mismatch("packet_echo", e.pkt, out_packet_echo);
        if (out_event_echo !== e.evt) mismatch("event_echo", e.evt, out_event_echo);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, expected.size());
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    int i;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, a full cluster on every reading closing on the
    // last channel, and a run broken just before completion
    pending.push_back(mk_channel('0, '0, '0, '0, '0, 1'b1));
    pending.push_back(mk_channel('1, '1, '0, '1, '1, 1'b1));
    pending.push_back(mk_channel('0, '0, '1, '0, '0, 1'b1));
    for (i = 0; i < RUN_LENGTH; i++)
      pending.push_back(mk_channel('1, '1, '1, 16'h5a5a, 32'hc0de_0001, i == RUN_LENGTH - 1));
    for (i = 0; i < RUN_LENGTH + 1; i++) begin
      if (i == RUN_LENGTH - 1)
        pending.push_back(mk_channel(10'h3fe, 10'h1ff, 10'h2ff, 16'ha5a5, 32'h1234_5678, 1'b0));
      else
        pending.push_back(mk_channel('1, '1, '1, 16'ha5a5, 32'h1234_5678, i == RUN_LENGTH));
    end
    queue_random(220);
    wait_drained();

    set_limits('0, '0, '0);
    no_idle = 1'b1;
    queue_random(220);
    wait_drained();
    no_idle = 1'b0;

    // one long packet pushes the total past the widest limit value
    set_limits('1, '1, '1);
    write_reg(REG_UNMAPPED, LIM_W'($urandom));
    queue_packet(LONG_ITEMS, 100);
    queue_random(80);
    wait_drained();

    repeat (3) begin
      set_limits(LIM_W'($urandom_range(30)), LIM_W'($urandom_range(12)),
                 LIM_W'($urandom_range(6)));
      queue_random(50);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (expected.size() != 0) begin
      errors++;
      $error("%0d expected results never arrived", expected.size());
    end
    $display("%0d channel transactions in, %0d results out, %0d register writes, %0d cycles",
             items_in, results_out, reg_writes, cycles);
    $display("packets by class: clean %0d, minor %0d, moderate %0d, severe %0d",
             class_seen[0], class_seen[1], class_seen[2], class_seen[3]);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
